// ----- rtl/core/fsba_pkg.sv -----
package fsba_pkg;

  // Default geometry
  localparam int unsigned NUM_BLOCKS  = 16;
  localparam int unsigned TABLE_DEPTH = 32;

  // Field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STRAT_W     = 2;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned AMOUNT_W    = 16;
  localparam int unsigned BLOCK_SEL_W = 4;
  localparam int unsigned STATUS_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Fit strategies: first ('F'), best ('B'), worst ('W')
  typedef enum logic [STRAT_W-1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_NONE  = 2'd3
  } strategy_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUP      = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Port controls of the block free-space memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } blk_ctl_t;

  // Port controls of the resident table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

endpackage

// ----- rtl/core/fsba_if.sv -----
interface fsba_req_if;
  logic                               valid;
  logic                               ready;
  logic [fsba_pkg::CMD_W-1:0]         cmd;
  logic [fsba_pkg::STRAT_W-1:0]       strategy;
  logic [fsba_pkg::ID_W-1:0]          proc_id;
  logic [fsba_pkg::AMOUNT_W-1:0]      amount;
  logic [fsba_pkg::BLOCK_SEL_W-1:0]   block_sel;

  modport source (output valid, cmd, strategy, proc_id, amount, block_sel, input ready);
  modport sink   (input valid, cmd, strategy, proc_id, amount, block_sel, output ready);
endinterface

interface fsba_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [fsba_pkg::STATUS_W-1:0]      status;
  logic [fsba_pkg::BLOCK_SEL_W-1:0]   placed_block;
  logic [fsba_pkg::AMOUNT_W-1:0]      free_after;

  modport source (output valid, status, placed_block, free_after, input ready);
  modport sink   (input valid, status, placed_block, free_after, output ready);
endinterface

// ----- rtl/core/fsba_block_mem.sv -----
module fsba_block_mem #(
  parameter  int unsigned NumBlocks = fsba_pkg::NUM_BLOCKS,
  localparam int unsigned BlkW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fsba_pkg::blk_ctl_t                ctl_i,
  input  logic [BlkW-1:0]                   rd_addr_i,
  input  logic [BlkW-1:0]                   wr_addr_i,
  input  logic [fsba_pkg::AMOUNT_W-1:0]     wr_data_i,
  output logic [fsba_pkg::AMOUNT_W-1:0]     rd_data_o
);

  logic [fsba_pkg::AMOUNT_W-1:0] mem_q [NumBlocks];
  logic [fsba_pkg::AMOUNT_W-1:0] rd_data_q;
  logic [NumBlocks-1:0]          vld_q;
  logic                          rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // A block never loaded reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/fsba_entry_table.sv -----
module fsba_entry_table #(
  parameter  int unsigned TableDepth = fsba_pkg::TABLE_DEPTH,
  parameter  int unsigned NumBlocks  = fsba_pkg::NUM_BLOCKS,
  localparam int unsigned TabW       = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned BlkW       = (NumBlocks > 1) ? $clog2(NumBlocks) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fsba_pkg::tbl_ctl_t                ctl_i,
  input  logic [TabW-1:0]                   rd_addr_i,
  input  logic [TabW-1:0]                   wr_addr_i,
  input  logic [fsba_pkg::ID_W-1:0]         wr_id_i,
  input  logic [fsba_pkg::AMOUNT_W-1:0]     wr_size_i,
  input  logic [BlkW-1:0]                   wr_blk_i,
  output logic                              rd_valid_o,
  output logic [fsba_pkg::ID_W-1:0]         rd_id_o,
  output logic [fsba_pkg::AMOUNT_W-1:0]     rd_size_o,
  output logic [BlkW-1:0]                   rd_blk_o
);

  localparam int unsigned WordW = fsba_pkg::ID_W + fsba_pkg::AMOUNT_W + BlkW;

  logic [WordW-1:0]      mem_q [TableDepth];
  logic [WordW-1:0]      rd_word_q;
  logic [TableDepth-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= {wr_id_i, wr_size_i, wr_blk_i};
    end
    if (ctl_i.rd_en) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // Occupancy: set on insert, drop on release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end else if (ctl_i.clr_en) begin
        vld_q[wr_addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_vld_q;
  assign rd_id_o    = rd_word_q[WordW-1 -: fsba_pkg::ID_W];
  assign rd_size_o  = rd_word_q[BlkW +: fsba_pkg::AMOUNT_W];
  assign rd_blk_o   = rd_word_q[BlkW-1:0];

endmodule

// ----- rtl/core/fit_strategy_block_allocator.sv -----
// Partition allocator: keeps the free space of NumBlocks memory blocks and a
// table of TableDepth resident processes, and answers every request with exactly
// one response. A load sets a block's capacity, an allocation places a process by
// first, best or worst fit (ties to the lowest block) and records it in the lowest
// free table entry, a release returns the entry's size to its block (saturating at
// 65535). One request is worked on at a time, and both the table and the block
// free space live in single-port synchronous memories that are scanned one entry a
// cycle. A load or unknown command goes from decode straight to the result state;
// an allocation runs the id scan over the table followed by the fit scan over the
// blocks; a release scans the table until the id is found, then reads its block
// and writes back the sum, and answers at the end of the scan if the id is not
// resident. A new request is taken while the previous response still waits in
// the output register. No clearing pass is needed after reset.
module fit_strategy_block_allocator #(
  parameter int unsigned NumBlocks  = fsba_pkg::NUM_BLOCKS,
  parameter int unsigned TableDepth = fsba_pkg::TABLE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsba_req_if.sink   req_i,
  fsba_rsp_if.source rsp_o
);

  localparam int unsigned BlkW    = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned TabW    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned BCntW   = $clog2(NumBlocks + 1);
  localparam int unsigned TCntW   = $clog2(TableDepth + 1);
  localparam int unsigned AmtW    = fsba_pkg::AMOUNT_W;
  localparam int unsigned IdW     = fsba_pkg::ID_W;
  localparam int unsigned BlkOutW = fsba_pkg::BLOCK_SEL_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_TSCAN  = 7'b0000100,
    S_BSCAN  = 7'b0001000,
    S_RREAD  = 7'b0010000,
    S_RWRITE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Latched request
  fsba_pkg::cmd_e      cmd_q;
  fsba_pkg::strategy_e strat_q;
  logic [IdW-1:0]      id_q;
  logic [AmtW-1:0]     amt_q;
  logic [BlkOutW-1:0]  sel_q;

  // Table scan
  logic [TCntW-1:0] tcnt_q, tcnt_d;
  logic             tpend_q, tpend_d;
  logic [TabW-1:0]  tidx_q, tidx_d;
  logic             slot_found_q, slot_found_d;
  logic [TabW-1:0]  slot_q, slot_d;

  // Block scan
  logic [BCntW-1:0] bcnt_q, bcnt_d;
  logic             bpend_q, bpend_d;
  logic [BlkW-1:0]  bidx_q, bidx_d;
  logic             chosen_q, chosen_d;
  logic [AmtW-1:0]  best_q, best_d;
  logic [BlkW-1:0]  best_idx_q, best_idx_d;

  // Release hit
  logic [BlkW-1:0]  hit_blk_q, hit_blk_d;
  logic [AmtW-1:0]  hit_size_q, hit_size_d;

  // Pending result and output register
  fsba_pkg::status_e  res_status_q, res_status_d;
  logic [BlkOutW-1:0] res_blk_q, res_blk_d;
  logic [AmtW-1:0]    res_free_q, res_free_d;
  logic               out_valid_q, out_valid_d;
  fsba_pkg::status_e  out_status_q, out_status_d;
  logic [BlkOutW-1:0] out_blk_q, out_blk_d;
  logic [AmtW-1:0]    out_free_q, out_free_d;

  // Memory ports
  fsba_pkg::blk_ctl_t blk_ctl;
  logic [BlkW-1:0]    blk_rd_addr, blk_wr_addr;
  logic [AmtW-1:0]    blk_wr_data, blk_rd_data;

  fsba_pkg::tbl_ctl_t tbl_ctl;
  logic [TabW-1:0]    tbl_rd_addr;
  logic [TabW-1:0]    tbl_wr_addr;
  logic               tbl_rd_valid;
  logic [IdW-1:0]     tbl_rd_id;
  logic [AmtW-1:0]    tbl_rd_size;
  logic [BlkW-1:0]    tbl_rd_blk;

  logic            req_fire;
  logic            tbl_hit, tbl_end, bscan_end, fits, take;
  logic [AmtW:0]   rel_sum;
  logic [AmtW-1:0] rel_sat, alloc_left;

  fsba_block_mem #(
    .NumBlocks (NumBlocks)
  ) u_block_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (blk_ctl),
    .rd_addr_i (blk_rd_addr),
    .wr_addr_i (blk_wr_addr),
    .wr_data_i (blk_wr_data),
    .rd_data_o (blk_rd_data)
  );

  fsba_entry_table #(
    .TableDepth (TableDepth),
    .NumBlocks  (NumBlocks)
  ) u_entry_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (tbl_ctl),
    .rd_addr_i  (tbl_rd_addr),
    .wr_addr_i  (tbl_wr_addr),
    .wr_id_i    (id_q),
    .wr_size_i  (amt_q),
    .wr_blk_i   (best_idx_q),
    .rd_valid_o (tbl_rd_valid),
    .rd_id_o    (tbl_rd_id),
    .rd_size_o  (tbl_rd_size),
    .rd_blk_o   (tbl_rd_blk)
  );

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Compare the entry read in the previous cycle
  assign tbl_hit = tpend_q && tbl_rd_valid && (tbl_rd_id == id_q);
  assign tbl_end = (tcnt_q == TCntW'(TableDepth)) && !tpend_q;

  assign bscan_end = (bcnt_q == BCntW'(NumBlocks)) && !bpend_q;
  assign fits      = bpend_q && (blk_rd_data >= amt_q);

  // Fit decision for the block just read; ties keep the lower index
  always_comb begin
    take = 1'b0;
    unique case (strat_q)
      fsba_pkg::STRAT_FIRST: take = fits && !chosen_q;
      fsba_pkg::STRAT_BEST:  take = fits && (blk_rd_data != '0) &&
                                    (!chosen_q || (blk_rd_data < best_q));
      fsba_pkg::STRAT_WORST: take = fits && (blk_rd_data != '0) &&
                                    (!chosen_q || (blk_rd_data > best_q));
      fsba_pkg::STRAT_NONE:  take = 1'b0;
    endcase
  end

  assign alloc_left = best_q - amt_q;
  assign rel_sum    = {1'b0, blk_rd_data} + {1'b0, hit_size_q};
  assign rel_sat    = rel_sum[AmtW] ? '1 : rel_sum[AmtW-1:0];

  always_comb begin
    state_d      = state_q;
    tcnt_d       = tcnt_q;
    tpend_d      = tpend_q;
    tidx_d       = tidx_q;
    slot_found_d = slot_found_q;
    slot_d       = slot_q;
    bcnt_d       = bcnt_q;
    bpend_d      = bpend_q;
    bidx_d       = bidx_q;
    chosen_d     = chosen_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    hit_blk_d    = hit_blk_q;
    hit_size_d   = hit_size_q;
    res_status_d = res_status_q;
    res_blk_d    = res_blk_q;
    res_free_d   = res_free_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_blk_d    = out_blk_q;
    out_free_d   = out_free_q;

    blk_ctl     = '0;
    blk_rd_addr = bcnt_q[BlkW-1:0];
    blk_wr_addr = best_idx_q;
    blk_wr_data = alloc_left;
    tbl_ctl     = '0;
    tbl_rd_addr = tcnt_q[TabW-1:0];
    tbl_wr_addr = slot_q;

    // Drop the response once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        tcnt_d       = '0;
        tpend_d      = 1'b0;
        slot_found_d = 1'b0;
        unique case (cmd_q)
          fsba_pkg::CMD_LOAD: begin
            // Overwrite the capacity; resident entries stay
            if (32'(sel_q) < NumBlocks) begin
              blk_ctl.wr_en = 1'b1;
              blk_wr_addr   = BlkW'(sel_q);
              blk_wr_data   = amt_q;
              res_status_d  = fsba_pkg::ST_OK;
              res_blk_d     = sel_q;
              res_free_d    = amt_q;
            end else begin
              res_status_d  = fsba_pkg::ST_NOFIT;
              res_blk_d     = '0;
              res_free_d    = '0;
            end
            state_d = S_DONE;
          end
          fsba_pkg::CMD_REQUEST,
          fsba_pkg::CMD_RELEASE: begin
            state_d = S_TSCAN;
          end
          fsba_pkg::CMD_NONE: begin
            res_status_d = fsba_pkg::ST_OK;
            res_blk_d    = '0;
            res_free_d   = '0;
            state_d      = S_DONE;
          end
        endcase
      end

      S_TSCAN: begin
        // Issue one table read a cycle, compare it the cycle after
        if (32'(tcnt_q) < TableDepth) begin
          tbl_ctl.rd_en = 1'b1;
          tcnt_d        = tcnt_q + TCntW'(1);
          tpend_d       = 1'b1;
          tidx_d        = tcnt_q[TabW-1:0];
        end else begin
          tpend_d = 1'b0;
        end
        if (tpend_q && !tbl_rd_valid && !slot_found_q) begin
          slot_found_d = 1'b1;
          slot_d       = tidx_q;
        end
        if (tbl_hit) begin
          if (cmd_q == fsba_pkg::CMD_REQUEST) begin
            res_status_d = fsba_pkg::ST_DUP;
            res_blk_d    = '0;
            res_free_d   = '0;
            state_d      = S_DONE;
          end else begin
            // Free the entry just compared and go return its size
            tbl_ctl.rd_en  = 1'b0;
            tbl_ctl.clr_en = 1'b1;
            tbl_wr_addr    = tidx_q;
            hit_blk_d      = tbl_rd_blk;
            hit_size_d     = tbl_rd_size;
            state_d        = S_RREAD;
          end
        end else if (tbl_end) begin
          bcnt_d   = '0;
          bpend_d  = 1'b0;
          chosen_d = 1'b0;
          if (cmd_q != fsba_pkg::CMD_REQUEST) begin
            res_status_d = fsba_pkg::ST_NOTFOUND;
            res_blk_d    = '0;
            res_free_d   = '0;
            state_d      = S_DONE;
          end else if (!slot_found_q) begin
            res_status_d = fsba_pkg::ST_FULL;
            res_blk_d    = '0;
            res_free_d   = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_BSCAN;
          end
        end
      end

      S_BSCAN: begin
        if (32'(bcnt_q) < NumBlocks) begin
          blk_ctl.rd_en = 1'b1;
          bcnt_d        = bcnt_q + BCntW'(1);
          bpend_d       = 1'b1;
          bidx_d        = bcnt_q[BlkW-1:0];
        end else begin
          bpend_d = 1'b0;
        end
        if (take) begin
          chosen_d   = 1'b1;
          best_d     = blk_rd_data;
          best_idx_d = bidx_q;
        end
        if (bscan_end) begin
          if (chosen_q) begin
            // Commit: shrink the block, record the resident
            blk_ctl.wr_en = 1'b1;
            tbl_ctl.wr_en = 1'b1;
            res_status_d  = fsba_pkg::ST_OK;
            res_blk_d     = BlkOutW'(best_idx_q);
            res_free_d    = alloc_left;
          end else begin
            res_status_d  = fsba_pkg::ST_NOFIT;
            res_blk_d     = '0;
            res_free_d    = '0;
          end
          state_d = S_DONE;
        end
      end

      S_RREAD: begin
        blk_ctl.rd_en = 1'b1;
        blk_rd_addr   = hit_blk_q;
        state_d       = S_RWRITE;
      end

      S_RWRITE: begin
        blk_ctl.wr_en = 1'b1;
        blk_wr_addr   = hit_blk_q;
        blk_wr_data   = rel_sat;
        res_status_d  = fsba_pkg::ST_OK;
        res_blk_d     = BlkOutW'(hit_blk_q);
        res_free_d    = rel_sat;
        state_d       = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_blk_d    = res_blk_q;
          out_free_d   = res_free_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tcnt_q       <= '0;
      tpend_q      <= 1'b0;
      slot_found_q <= 1'b0;
      bcnt_q       <= '0;
      bpend_q      <= 1'b0;
      chosen_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tcnt_q       <= tcnt_d;
      tpend_q      <= tpend_d;
      slot_found_q <= slot_found_d;
      bcnt_q       <= bcnt_d;
      bpend_q      <= bpend_d;
      chosen_q     <= chosen_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q   <= fsba_pkg::cmd_e'(req_i.cmd);
      strat_q <= fsba_pkg::strategy_e'(req_i.strategy);
      id_q    <= req_i.proc_id;
      amt_q   <= req_i.amount;
      sel_q   <= req_i.block_sel;
    end
    tidx_q       <= tidx_d;
    slot_q       <= slot_d;
    bidx_q       <= bidx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    hit_blk_q    <= hit_blk_d;
    hit_size_q   <= hit_size_d;
    res_status_q <= res_status_d;
    res_blk_q    <= res_blk_d;
    res_free_q   <= res_free_d;
    out_status_q <= out_status_d;
    out_blk_q    <= out_blk_d;
    out_free_q   <= out_free_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.placed_block = out_blk_q;
  assign rsp_o.free_after   = out_free_q;

`ifndef ASSERT_OFF
  // An accepted request always moves into decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_EXEC))
    else $error("accepted request did not enter decode");

  // A table insert only happens with a free slot and a chosen block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_ctl.wr_en |-> (slot_found_q && chosen_q && (state_q == S_BSCAN)))
    else $error("table insert without free slot or chosen block");

  // The single-port block memory never reads and writes in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(blk_ctl.rd_en && blk_ctl.wr_en))
    else $error("block memory read and write collide");

  // A response appears only when leaving the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == S_DONE))
    else $error("response raised outside the result state");
`endif

endmodule

// ----- tb/sv/fsba_placement_checker.sv -----
`timescale 1ns / 1ps
module fsba_placement_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsba_req_if         req_i,
  fsba_rsp_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned responses_o,
  output int unsigned full_hits_o,
  output int unsigned dup_hits_o,
  output int unsigned sat_hits_o
);
  import fsba_pkg::*;

  typedef struct packed {
    status_e                  status;
    logic [BLOCK_SEL_W-1:0]   block;
    logic [AMOUNT_W-1:0]      free;
  } placement_t;

  // Shadow of the allocator state
  logic [AMOUNT_W-1:0]    blk_free  [NUM_BLOCKS];
  logic                   res_valid [TABLE_DEPTH];
  logic [ID_W-1:0]        res_id    [TABLE_DEPTH];
  logic [AMOUNT_W-1:0]    res_size  [TABLE_DEPTH];
  logic [BLOCK_SEL_W-1:0] res_block [TABLE_DEPTH];

  placement_t  expected_placements [$];
  placement_t  want;
  placement_t  fresh;
  int unsigned err_cnt;
  int unsigned rsp_cnt;
  int unsigned full_cnt;
  int unsigned dup_cnt;
  int unsigned sat_cnt;

  assign errors_o    = err_cnt;
  assign pending_o   = expected_placements.size();
  assign responses_o = rsp_cnt;
  assign full_hits_o = full_cnt;
  assign dup_hits_o  = dup_cnt;
  assign sat_hits_o  = sat_cnt;

  task automatic report(string msg);
    err_cnt++;
    $display("[%0t] placement mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp_v);
    if (got != exp_v) begin
      report($sformatf("%s got %0d, expected %0d", name, got, exp_v));
    end
  endtask

  // Lowest resident entry holding this id, or -1
  function automatic int find_resident(logic [ID_W-1:0] id);
    int i;
    find_resident = -1;
    for (i = int'(TABLE_DEPTH) - 1; i >= 0; i--) begin
      if (res_valid[i] && res_id[i] == id) find_resident = i;
    end
  endfunction

  function automatic placement_t predict_placement(cmd_e cmd, strategy_e strat,
                                                   logic [ID_W-1:0] id,
                                                   logic [AMOUNT_W-1:0] amt,
                                                   logic [BLOCK_SEL_W-1:0] sel);
    placement_t       res;
    int               i;
    int               entry;
    int               slot;
    int               pick;
    logic [AMOUNT_W:0] sum;
    res   = '{status: ST_OK, block: '0, free: '0};
    slot  = -1;
    pick  = -1;
    case (cmd)
      CMD_LOAD: begin
        if (int'(sel) < int'(NUM_BLOCKS)) begin
          blk_free[sel] = amt;
          res.block     = sel;
          res.free      = amt;
        end else begin
          res.status = ST_NOFIT;
        end
      end
      CMD_REQUEST: begin
        for (i = int'(TABLE_DEPTH) - 1; i >= 0; i--) begin
          if (!res_valid[i]) slot = i;
        end
        if (find_resident(id) >= 0) begin
          res.status = ST_DUP;
          dup_cnt++;
        end else if (slot < 0) begin
          res.status = ST_FULL;
          full_cnt++;
        end else begin
          for (i = 0; i < int'(NUM_BLOCKS); i++) begin
            if (blk_free[i] >= amt) begin
              case (strat)
                STRAT_FIRST: if (pick < 0) pick = i;
                STRAT_BEST: begin
                  if (blk_free[i] != '0 && (pick < 0 || blk_free[i] < blk_free[pick])) pick = i;
                end
                STRAT_WORST: begin
                  if (blk_free[i] != '0 && (pick < 0 || blk_free[i] > blk_free[pick])) pick = i;
                end
                default: ;
              endcase
            end
          end
          if (pick < 0) begin
            res.status = ST_NOFIT;
          end else begin
            blk_free[pick]  = blk_free[pick] - amt;
            res_valid[slot] = 1'b1;
            res_id[slot]    = id;
            res_size[slot]  = amt;
            res_block[slot] = BLOCK_SEL_W'(pick);
            res.block       = BLOCK_SEL_W'(pick);
            res.free        = blk_free[pick];
          end
        end
      end
      CMD_RELEASE: begin
        entry = find_resident(id);
        if (entry < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res_valid[entry] = 1'b0;
          sum = {1'b0, blk_free[res_block[entry]]} + {1'b0, res_size[entry]};
          if (sum[AMOUNT_W]) begin
            sum = {1'b0, {AMOUNT_W{1'b1}}};
            sat_cnt++;
          end
          blk_free[res_block[entry]] = sum[AMOUNT_W-1:0];
          res.block                  = res_block[entry];
          res.free                   = sum[AMOUNT_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_BLOCKS); i++) blk_free[i] = '0;
      for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
        res_valid[i] = 1'b0;
        res_id[i]    = '0;
        res_size[i]  = '0;
        res_block[i] = '0;
      end
      expected_placements.delete();
      err_cnt  = 0;
      rsp_cnt  = 0;
      full_cnt = 0;
      dup_cnt  = 0;
      sat_cnt  = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        fresh = predict_placement(cmd_e'(req_i.cmd), strategy_e'(req_i.strategy),
                                  req_i.proc_id, req_i.amount, req_i.block_sel);
        expected_placements.insert(expected_placements.size(), fresh);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_cnt++;
        if (expected_placements.size() == 0) begin
          report($sformatf("response status %0d block %0d free %0d with nothing outstanding",
                           rsp_i.status, rsp_i.placed_block, rsp_i.free_after));
        end else begin
          want = expected_placements.pop_front();
          check_field("status", rsp_i.status, want.status);
          check_field("placed_block", rsp_i.placed_block, want.block);
          check_field("free_after", rsp_i.free_after, want.free);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import fsba_pkg::*;

  // Random part: rounds of requests, each round leaning towards filling,
  // churning or draining the resident table
  localparam int unsigned RoundCount   = 10;
  localparam int unsigned RoundLength  = 70;
  // Ids mostly come from a pool a little larger than the table, so that
  // duplicates, misses and a full table all turn up
  localparam int unsigned IdPool       = 36;
  // Cycles without any handshake before the run is declared hung
  localparam int unsigned IdleLimit    = 2000;
  // Settling time after the last response
  localparam int unsigned DrainCycles  = 64;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_STRIDE,
    RX_BURSTY
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fsba_req_if req_if ();
  fsba_rsp_if rsp_if ();

  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned chk_responses;
  int unsigned chk_full;
  int unsigned chk_dup;
  int unsigned chk_sat;

  int unsigned     cmd_seen [4];
  int unsigned     burst_left;
  int unsigned     idle_cycles;
  logic [ID_W-1:0] resident_ids [$];

  fit_strategy_block_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  fsba_placement_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .errors_o    (chk_errors),
    .pending_o   (chk_pending),
    .responses_o (chk_responses),
    .full_hits_o (chk_full),
    .dup_hits_o  (chk_dup),
    .sat_hits_o  (chk_sat)
  );

  // 12 ns clock, first rising edge at 6 ns
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hand one request to the block. The sender works in bursts: when a burst
  // runs out, drop valid for a random gap, or go on at once, before starting the next one.
  // Drive at the falling edge; the request is taken at the first rising edge
  // that sees ready high.
  task automatic send_request(cmd_e cmd, strategy_e strat, logic [ID_W-1:0] id,
                              logic [AMOUNT_W-1:0] amt, logic [BLOCK_SEL_W-1:0] sel);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.cmd       = cmd;
    req_if.strategy  = strat;
    req_if.proc_id   = id;
    req_if.amount    = amt;
    req_if.block_sel = sel;
    req_if.valid     = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    cmd_seen[cmd]++;
  endtask

  // Build one random request. req_pct and rel_pct set the share of
  // allocations and releases; loads and idle commands fill the rest.
  task automatic random_request(int unsigned req_pct, int unsigned rel_pct);
    int unsigned         roll;
    int unsigned         pos;
    logic [ID_W-1:0]     id;
    logic [AMOUNT_W-1:0] amt;
    strategy_e           strat;
    roll  = $urandom_range(0, 99);
    // Mostly the three real strategies, now and then the undefined code
    strat = ($urandom_range(0, 9) == 0) ? STRAT_NONE : strategy_e'($urandom_range(0, 2));
    id    = ($urandom_range(0, 6) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, IdPool - 1));
    if (roll < req_pct) begin
      // Sizes: mostly small so that placements succeed, with zero, huge and
      // full-range sizes mixed in
      case ($urandom_range(0, 19))
        0:       amt = '0;
        1:       amt = AMOUNT_W'($urandom);
        2, 3:    amt = AMOUNT_W'($urandom_range(20000, 65535));
        default: amt = AMOUNT_W'($urandom_range(1, 1500));
      endcase
      resident_ids.insert(resident_ids.size(), id);
      send_request(CMD_REQUEST, strat, id, amt, BLOCK_SEL_W'($urandom));
    end else if (roll < req_pct + rel_pct) begin
      // Prefer an id that was asked for earlier, so that most releases hit
      if (resident_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
        pos = $urandom_range(0, resident_ids.size() - 1);
        id  = resident_ids[pos];
        resident_ids.delete(pos);
      end
      send_request(CMD_RELEASE, strat, id, AMOUNT_W'($urandom), BLOCK_SEL_W'($urandom));
    end else if (roll < 96) begin
      // Capacities: empty, full scale, full range or a typical middle size
      case ($urandom_range(0, 9))
        0:       amt = '0;
        1, 2:    amt = '1;
        3:       amt = AMOUNT_W'($urandom);
        default: amt = AMOUNT_W'($urandom_range(2000, 20000));
      endcase
      send_request(CMD_LOAD, strat, id, amt, BLOCK_SEL_W'($urandom));
    end else begin
      send_request(CMD_NONE, strat, id, AMOUNT_W'($urandom), BLOCK_SEL_W'($urandom));
    end
  endtask

  // Response side: hold a stall pattern for a while, then switch to another.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned stride;
    int unsigned stall_left;
    int unsigned tick;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      mode   = rx_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(40, 160);
      stride = $urandom_range(2, 6);
      for (tick = 0; tick < span; tick++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:   rsp_if.ready = 1'b1;
          RX_RANDOM: rsp_if.ready = ($urandom_range(0, 99) < 60);
          RX_STRIDE: rsp_if.ready = (tick % stride == 0);
          default: begin
            if (stall_left > 0) begin
              rsp_if.ready = 1'b0;
              stall_left--;
            end else begin
              rsp_if.ready = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 25);
            end
          end
        endcase
      end
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[fit_strategy_block_allocator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned round_i;
    int unsigned item_i;
    int unsigned req_pct;
    int unsigned rel_pct;

    // Drive every input to a known value before reset is released
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_LOAD;
    req_if.strategy  = STRAT_FIRST;
    req_if.proc_id   = '0;
    req_if.amount    = '0;
    req_if.block_sel = '0;
    burst_left       = 0;
    idle_cycles      = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Every block starts empty.
    // First fit with a zero size takes an empty block 0
    send_request(CMD_REQUEST, STRAT_FIRST, 8'h00, 16'd0, 4'd0);
    // Best fit skips empty blocks, so nothing fits
    send_request(CMD_REQUEST, STRAT_BEST, 8'h01, 16'd0, 4'd0);
    send_request(CMD_RELEASE, STRAT_FIRST, 8'h00, 16'd0, 4'd0);
    // Release of an id that was never resident
    send_request(CMD_RELEASE, STRAT_WORST, 8'hFF, 16'hFFFF, 4'hF);
    send_request(CMD_LOAD, STRAT_FIRST, 8'h00, 16'd100, 4'd0);
    send_request(CMD_LOAD, STRAT_FIRST, 8'h00, 16'd50, 4'd3);
    send_request(CMD_LOAD, STRAT_FIRST, 8'h00, 16'hFFFF, 4'd7);
    send_request(CMD_LOAD, STRAT_FIRST, 8'h00, 16'd50, 4'd15);
    send_request(CMD_REQUEST, STRAT_FIRST, 8'h02, 16'd40, 4'd0);
    // Best fit ties between blocks 3 and 15: the lower index wins
    send_request(CMD_REQUEST, STRAT_BEST, 8'h03, 16'd30, 4'd0);
    send_request(CMD_REQUEST, STRAT_WORST, 8'h04, 16'd10, 4'd0);
    // Id already resident
    send_request(CMD_REQUEST, STRAT_FIRST, 8'h02, 16'd1, 4'd0);
    // Undefined strategy places nothing
    send_request(CMD_REQUEST, STRAT_NONE, 8'h05, 16'd1, 4'd0);
    send_request(CMD_REQUEST, STRAT_FIRST, 8'h06, 16'hFFFF, 4'd0);
    // Reload a block that holds a resident process, then release it: the
    // returned space saturates
    send_request(CMD_LOAD, STRAT_FIRST, 8'h00, 16'hFFFF, 4'd7);
    send_request(CMD_RELEASE, STRAT_FIRST, 8'h04, 16'd0, 4'd0);
    // Undefined command with every field set
    send_request(CMD_NONE, STRAT_NONE, 8'hFF, 16'hFFFF, 4'hF);
    send_request(CMD_RELEASE, STRAT_FIRST, 8'h03, 16'd0, 4'd0);
    send_request(CMD_REQUEST, STRAT_WORST, 8'hFF, 16'hFFFF, 4'd0);
    send_request(CMD_RELEASE, STRAT_BEST, 8'hFF, 16'd0, 4'd0);
    send_request(CMD_RELEASE, STRAT_FIRST, 8'h02, 16'd0, 4'd0);

    // Random part: cycle through fill, churn and drain rounds so that the
    // table runs full and empties again several times
    for (round_i = 0; round_i < RoundCount; round_i++) begin
      case (round_i % 3)
        0: begin
          req_pct = 65;
          rel_pct = 15;
        end
        1: begin
          req_pct = 40;
          rel_pct = 40;
        end
        default: begin
          req_pct = 20;
          rel_pct = 65;
        end
      endcase
      for (item_i = 0; item_i < RoundLength; item_i++) random_request(req_pct, rel_pct);
    end

    // Stop sending and wait for every outstanding response
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (chk_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d loads, %0d allocations, %0d releases, %0d idle commands; %0d responses.",
             cmd_seen[CMD_LOAD], cmd_seen[CMD_REQUEST], cmd_seen[CMD_RELEASE],
             cmd_seen[CMD_NONE], chk_responses);
    $display("Hit a full table %0d times, duplicate ids %0d times, saturated releases %0d times.",
             chk_full, chk_dup, chk_sat);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("[fit_strategy_block_allocator] OK");
    end else begin
      $display("[fit_strategy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
